// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the depth sorter
// used by the top level only; needs clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define PDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define PDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pds_pkg.sv -----
// shared types and constants for the depth sorter
// no dependencies
`default_nettype none

package pds_pkg;

  localparam int MAX_ITEMS_DEF = 32;
  localparam int IDX_W         = 5;
  localparam int COORD_W       = 8;
  localparam int KEY_W         = 9;

  // input beat
  typedef struct packed {
    logic [IDX_W-1:0]   obj_index;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               final_item;
  } pds_in_t;

  // result beat
  typedef struct packed {
    logic [IDX_W-1:0] sorted_index;
    logic [KEY_W-1:0] depth_key;
    logic             last_out;
    logic             overflowed;
  } pds_out_t;

  // one sorted store entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } pds_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pds_store.sv -----
// sorted entry store: one write port, one read port with registered data
// depends on pds_pkg
`default_nettype none

module pds_store #(
  parameter int MAX_ITEMS = pds_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_ITEMS)-1:0] wr_addr,
  input  wire pds_pkg::pds_entry_t          wr_data,
  input  wire logic [$clog2(MAX_ITEMS)-1:0] rd_addr,
  output pds_pkg::pds_entry_t               rd_data
);

  pds_pkg::pds_entry_t mem [MAX_ITEMS];
  pds_pkg::pds_entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/pds_ctrl.sv -----
// sequencer and shared key comparator of the depth sorter
// depends on pds_pkg; drives pds_store through its write and read ports
`default_nettype none

module pds_ctrl #(
  parameter int MAX_ITEMS = pds_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire pds_pkg::pds_in_t             in_data,
  output logic                              in_stall,
  output logic                              emit_valid,
  output pds_pkg::pds_out_t                 emit_data,
  input  wire logic                         emit_ready,
  output logic                              wr_en,
  output logic [$clog2(MAX_ITEMS)-1:0]      wr_addr,
  output pds_pkg::pds_entry_t               wr_data,
  output logic [$clog2(MAX_ITEMS)-1:0]      rd_addr,
  input  wire pds_pkg::pds_entry_t          rd_data
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_PLACE = 3'd3;
  localparam logic [2:0] ST_OREAD = 3'd4;
  localparam logic [2:0] ST_OEMIT = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic                       drop_r, drop_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [pds_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [pds_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                       final_r, final_nxt;

  logic                       in_take;
  logic                       has_room;
  logic                       is_last;
  logic [pds_pkg::KEY_W-1:0]  in_key;
  logic [2:0]                 done_state;
  pds_pkg::pds_entry_t        new_entry;

  assign in_take    = in_valid && !in_stall;
  assign has_room   = fill_r < CW'(MAX_ITEMS);
  assign is_last    = (CW'(ptr_r) + CW'(1)) == fill_r;
  assign in_key     = {1'b0, in_data.pos_x} + {1'b0, in_data.pos_y};
  assign new_entry  = '{key: key_r, idx: idx_r};
  // after an insert: a final item starts the output run
  assign done_state = final_r ? ST_OREAD : ST_IDLE;

  assign in_stall   = state_r != ST_IDLE;
  assign emit_valid = state_r == ST_OEMIT;
  assign emit_data  = '{sorted_index: rd_data.idx, depth_key: rd_data.key,
                        last_out: is_last, overflowed: drop_r};

  // read address: output pointer during the run, else the entry below the hole
  always_comb begin
    if (state_r == ST_OREAD || state_r == ST_OEMIT) begin
      rd_addr = ptr_r;
    end else begin
      rd_addr = pos_r - AW'(1);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    drop_nxt  = drop_r;
    pos_nxt   = pos_r;
    ptr_nxt   = ptr_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    final_nxt = final_r;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = new_entry;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          key_nxt   = in_key;
          idx_nxt   = in_data.obj_index;
          final_nxt = in_data.final_item;
          ptr_nxt   = '0;
          if (!has_room) begin
            drop_nxt  = 1'b1;
            state_nxt = in_data.final_item ? ST_OREAD : ST_IDLE;
          end else if (fill_r == '0) begin
            // empty store: place directly at the bottom
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = '{key: in_key, idx: in_data.obj_index};
            fill_nxt  = fill_r + CW'(1);
            state_nxt = in_data.final_item ? ST_OREAD : ST_IDLE;
          end else begin
            pos_nxt   = fill_r[AW-1:0];
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        wr_en = 1'b1;
        if (rd_data.key > key_r) begin
          // strictly greater key moves up one slot
          wr_data = rd_data;
          pos_nxt = pos_r - AW'(1);
          state_nxt = (pos_r == AW'(1)) ? ST_PLACE : ST_READ;
        end else begin
          fill_nxt  = fill_r + CW'(1);
          state_nxt = done_state;
        end
      end
      ST_PLACE: begin
        wr_en     = 1'b1;
        fill_nxt  = fill_r + CW'(1);
        state_nxt = done_state;
      end
      ST_OREAD: begin
        state_nxt = ST_OEMIT;
      end
      ST_OEMIT: begin
        if (emit_ready) begin
          if (is_last) begin
            fill_nxt  = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = ST_OREAD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    ptr_r   <= ptr_nxt;
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    final_r <= final_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/painter_depth_sorter.sv -----
// Stable depth sorter: each input beat is inserted by key pos_x + pos_y into a sorted
// store, after every entry of equal or smaller key; a beat with final_item set starts
// an output run of all stored entries in ascending key order, last_out on the final
// one and overflowed on every one when items past MAX_ITEMS were dropped from the set.
// Insertion walks down the store with one compare unit and one memory read and write
// port, each entry that moves up taking a memory read, then a compare and write; an
// item into an empty store is placed directly and one into a full store is dropped.
// The output run reads each result from memory, then loads the output register, and
// out_stall can hold it. No clearing pass after reset: only filled entries are used.
// depends on pds_pkg, pds_store, pds_ctrl and assert_macros.svh
`default_nettype none

module painter_depth_sorter #(
  parameter int MAX_ITEMS = pds_pkg::MAX_ITEMS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire pds_pkg::pds_in_t  in_data,
  output logic                   in_stall,
  output logic                   out_valid,
  output pds_pkg::pds_out_t      out_data,
  input  wire logic              out_stall
);

  localparam int AW = $clog2(MAX_ITEMS);

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  pds_pkg::pds_entry_t  wr_data;
  logic [AW-1:0]        rd_addr;
  pds_pkg::pds_entry_t  rd_data;

  logic                 emit_valid;
  logic                 emit_ready;
  logic                 emit_take;
  pds_pkg::pds_out_t    emit_data;

  logic                 out_valid_r, out_valid_nxt;
  pds_pkg::pds_out_t    out_data_r;

  pds_store #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pds_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .emit_valid (emit_valid),
    .emit_data  (emit_data),
    .emit_ready (emit_ready),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // output register: loads when empty or when its beat leaves this cycle
  assign emit_ready    = !out_valid_r || !out_stall;
  assign emit_take     = emit_valid && emit_ready;
  assign out_valid_nxt = emit_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
`include "assert_macros.svh"

  `PDS_ASSERT_NOW(a_emit_blocks_input, emit_valid, in_stall, "result emitted while input open")
  `PDS_ASSERT_NEXT(a_last_frees_input, emit_take && emit_data.last_out, !in_stall,
    "input not reopened after last result")
  `PDS_ASSERT_NEXT(a_no_emit_after_accept, in_valid && !in_stall, !emit_valid,
    "result emitted right after an input beat")

endmodule

`default_nettype wire
